// File: src/swtmr_pkg.sv
`default_nettype none
package swtmr_pkg;

   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 3;
   localparam int DELAY_W  = 16;
   localparam int TIME_W   = 32;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [DELAY_W-1:0]  delay_type;
   typedef logic [TIME_W-1:0]   time_type;

   // request operation codes
   localparam op_type OP_TICK   = 3'd0;
   localparam op_type OP_ADD    = 3'd1;
   localparam op_type OP_REMOVE = 3'd2;
   localparam op_type OP_TAKE   = 3'd3;
   localparam op_type OP_SET    = 3'd4;

   // response status codes
   localparam status_type STAT_OK         = 2'd0;
   localparam status_type STAT_ARMED      = 2'd1;
   localparam status_type STAT_NOT_ARMED  = 2'd2;
   localparam status_type STAT_NONE_READY = 2'd3;

endpackage
`default_nettype wire

// File: src/software_timer_task_table.sv
`default_nettype none
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ----------------------------------------------
// req       in         req_valid / req_ready  operation, slot_index, start_delay,
//                                             repeat_period, new_time
// rsp       out        rsp_valid / rsp_ready  status, ready_slot, time_now
//
// One request at a time. A tick walks the slot table through one shared
// countdown/reload unit, one slot per cycle with the table read overlapped with the
// write-back. A take scans the armed/ready bits one slot per cycle and stops at the
// first ready slot. Reset (synchronous, active high) clears armed and ready bits
// and the time counter; the countdown/period table is only used for armed slots,
// so it needs no clearing.
// The response sits in an output register; req_ready returns as soon as it is loaded,
// so a stalled rsp side only holds the block when a second response is ready.
module software_timer_task_table #(
   parameter int NUM_SLOTS  = 8,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire swtmr_pkg::op_type      req_operation,
   input  wire swtmr_pkg::slot_type    req_slot_index,
   input  wire swtmr_pkg::delay_type   req_start_delay,
   input  wire swtmr_pkg::delay_type   req_repeat_period,
   input  wire swtmr_pkg::time_type    req_new_time,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      swtmr_pkg::status_type  rsp_status,
   output      swtmr_pkg::slot_type    rsp_ready_slot,
   output      swtmr_pkg::time_type    rsp_time_now
);
   import swtmr_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_SLOTS);

   typedef enum logic [1:0] {ST_IDLE, ST_TICK, ST_TAKE, ST_FINISH} state_type;

   state_type              state_ff;
   logic [NUM_SLOTS-1:0]   armed_ff;
   logic [NUM_SLOTS-1:0]   ready_ff;
   logic [NUM_SLOTS-1:0]   oneshot_ff;   // period is zero
   time_type               time_ff;
   logic [CNT_W-1:0]       scan_ff;      // read pointer of the slot walk
   logic                   pend_ff;      // read data waits for write-back
   logic [IDX_W-1:0]       wb_ff;        // slot being written back
   status_type             stat_ff;
   slot_type               slot_ff;
   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   slot_type               rsp_slot_ff;
   time_type               rsp_time_ff;

   // countdown / period table
   logic [COUNT_BITS-1:0]  cd_mem  [NUM_SLOTS];
   logic [COUNT_BITS-1:0]  per_mem [NUM_SLOTS];
   logic [COUNT_BITS-1:0]  rd_cd_ff;
   logic [COUNT_BITS-1:0]  rd_per_ff;

   logic                   req_acc;
   logic [31:0]            idx_ext;
   logic                   idx_ok;
   logic [IDX_W-1:0]       slot_sel;
   logic                   armed_hit;
   logic                   add_ok;
   logic [31:0]            delay_ext;
   logic [31:0]            period_ext;
   logic [COUNT_BITS-1:0]  delay_in;
   logic [COUNT_BITS-1:0]  period_in;
   logic [IDX_W-1:0]       scan_idx;
   logic                   scan_live;
   logic [IDX_W-1:0]       rd_addr;
   logic [31:0]            scan_ext;

   // shared countdown unit
   logic                   both_zero;
   logic [COUNT_BITS-1:0]  cd_dec;
   logic                   tick_expire;
   logic [COUNT_BITS-1:0]  cd_next;
   logic                   tick_wr;

   logic                   cd_we;
   logic [IDX_W-1:0]       cd_wa;
   logic [COUNT_BITS-1:0]  cd_wd;
   logic                   per_we;

   assign req_ready      = (state_ff == ST_IDLE);
   assign req_acc        = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_ready_slot = rsp_slot_ff;
   assign rsp_time_now   = rsp_time_ff;

   // request decode; slot indexes past the table are rejected
   assign idx_ext    = 32'(req_slot_index);
   assign idx_ok     = idx_ext < 32'(NUM_SLOTS);
   assign slot_sel   = idx_ext[IDX_W-1:0];
   assign armed_hit  = idx_ok && armed_ff[slot_sel];
   assign add_ok     = idx_ok && !armed_ff[slot_sel];
   assign delay_ext  = 32'(req_start_delay);
   assign period_ext = 32'(req_repeat_period);
   assign delay_in   = delay_ext[COUNT_BITS-1:0];
   assign period_in  = period_ext[COUNT_BITS-1:0];

   assign scan_idx   = scan_ff[IDX_W-1:0];
   assign scan_live  = scan_ff < SCAN_END;
   assign rd_addr    = scan_live ? scan_idx : '0;
   assign scan_ext   = 32'(scan_ff);

   // one slot per cycle: zero/zero stays expired, else decrement and reload on zero
   assign both_zero   = (rd_cd_ff == '0) && (rd_per_ff == '0);
   assign cd_dec      = rd_cd_ff - 1'b1;
   assign tick_expire = both_zero || (cd_dec == '0);
   assign cd_next     = (cd_dec == '0) ? rd_per_ff : cd_dec;
   assign tick_wr     = (state_ff == ST_TICK) && pend_ff && armed_ff[wb_ff] && !both_zero;

   assign per_we = req_acc && (req_operation == OP_ADD) && add_ok;
   assign cd_we  = per_we || tick_wr;
   assign cd_wa  = tick_wr ? wb_ff : slot_sel;
   assign cd_wd  = tick_wr ? cd_next : delay_in;

   always_ff @(posedge clock) begin
      if (cd_we) begin
         cd_mem[cd_wa] <= cd_wd;
      end
      if (per_we) begin
         per_mem[slot_sel] <= period_in;
      end
      rd_cd_ff  <= cd_mem[rd_addr];
      rd_per_ff <= per_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         armed_ff     <= '0;
         ready_ff     <= '0;
         time_ff      <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // FINISH reloads the output register on its own handshake
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  slot_ff  <= '0;
                  scan_ff  <= '0;
                  pend_ff  <= 1'b0;
                  unique case (req_operation)
                     OP_TICK: begin
                        stat_ff  <= STAT_OK;
                        time_ff  <= time_ff + 1'b1;
                        state_ff <= ST_TICK;
                     end
                     OP_ADD: begin
                        state_ff <= ST_FINISH;
                        if (!add_ok) begin
                           stat_ff <= STAT_ARMED;
                        end else begin
                           stat_ff              <= STAT_OK;
                           armed_ff[slot_sel]   <= 1'b1;
                           ready_ff[slot_sel]   <= 1'b0;
                           oneshot_ff[slot_sel] <= (period_in == '0);
                        end
                     end
                     OP_REMOVE: begin
                        state_ff <= ST_FINISH;
                        if (!armed_hit) begin
                           stat_ff <= STAT_NOT_ARMED;
                        end else begin
                           stat_ff            <= STAT_OK;
                           armed_ff[slot_sel] <= 1'b0;
                           ready_ff[slot_sel] <= 1'b0;
                        end
                     end
                     OP_TAKE: begin
                        stat_ff  <= STAT_OK;
                        state_ff <= ST_TAKE;
                     end
                     OP_SET: begin
                        stat_ff  <= STAT_OK;
                        time_ff  <= req_new_time;
                        state_ff <= ST_FINISH;
                     end
                     default: begin
                        stat_ff  <= STAT_OK;
                        state_ff <= ST_FINISH;
                     end
                  endcase
               end
            end
            ST_TICK: begin
               if (scan_live) begin
                  scan_ff <= scan_ff + 1'b1;
                  wb_ff   <= scan_idx;
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
               end
               if (pend_ff && armed_ff[wb_ff] && tick_expire) begin
                  ready_ff[wb_ff] <= 1'b1;
               end
               if (pend_ff && !scan_live) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_TAKE: begin
               if (!scan_live) begin
                  stat_ff  <= STAT_NONE_READY;
                  state_ff <= ST_FINISH;
               end else if (armed_ff[scan_idx] && ready_ff[scan_idx]) begin
                  ready_ff[scan_idx] <= 1'b0;
                  if (oneshot_ff[scan_idx]) begin
                     armed_ff[scan_idx] <= 1'b0;
                  end
                  slot_ff  <= scan_ext[SLOT_W-1:0];
                  state_ff <= ST_FINISH;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= stat_ff;
                  rsp_slot_ff   <= slot_ff;
                  rsp_time_ff   <= time_ff;
                  state_ff      <= ST_IDLE;
               end
            end
         endcase
      end
   end

   // a slot is only ever marked ready while armed
   a_ready_armed: assert property (@(posedge clock) disable iff (reset)
      (ready_ff & ~armed_ff) == '0)
      else $error("ready mark on a disarmed slot");

   // an accepted request always leaves idle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != ST_IDLE)
      else $error("request accepted without starting work");

   // the time counter moves only when a request is taken
   a_time_hold: assert property (@(posedge clock) disable iff (reset)
      !req_acc |=> $stable(time_ff))
      else $error("time counter changed without a request");

   // the slot walk never runs past the table
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> scan_ff <= SCAN_END)
      else $error("slot scan out of range");

endmodule
`default_nettype wire
